// ===== src/trg_pkg.sv =====
// Shared types, codes and fixed-point constants of the transient restore gain block.
`timescale 1ns / 1ps

package trg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ATTACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_DEPTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE  = 3'd6;

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [23:0] EPS_Q23   = 24'd839;
    localparam logic [15:0] K035      = 16'd22938;
    localparam logic [15:0] K065      = 16'd42598;
    localparam logic [15:0] K028      = 16'd18350;
    localparam logic [15:0] UNITY_Q14 = 16'd16384;
    localparam logic [23:0] MAG_MAX   = 24'd8388607;
    localparam logic [23:0] MAG_MIN   = 24'h800000;

    // Hardness saturates once drive * scale reaches 65536 * 12288.
    localparam logic [31:0] HARD_SAT = 32'd805306368;
    // ceil(2^20 / 3): exact floor division by three for values below 2^19.
    localparam logic [18:0] RECIP3   = 19'd349526;

    // Quotient bits produced by the divider, one per cycle.
    localparam int DIV_STEPS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_FAST,
        ST_SLOW,
        ST_HARD,
        ST_DIV3,
        ST_FACTOR,
        ST_DEPTH,
        ST_NUM,
        ST_DEN,
        ST_GDIV,
        ST_GWAIT,
        ST_DONE
    } t_state;

    // One entry of the per-channel state memory.
    typedef struct packed {
        logic [23:0] fast;
        logic [23:0] slow;
        logic [15:0] drive;
    } t_env_entry;

    typedef struct packed {
        logic                 start;
        logic [23:0]          rem_init;
        logic [DIV_STEPS-1:0] low;
        logic [23:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic [DIV_STEPS-1:0] quot;
    } t_div_stat;

endpackage

// ===== src/trg_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module trg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trg_pkg::t_div_req   i_req,
    output trg_pkg::t_div_stat  o_stat
);

    localparam int QW = trg_pkg::DIV_STEPS;
    localparam int CW = $clog2(QW);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [23:0]   r_rem, n_rem;
    logic [23:0]   r_dvs, n_dvs;
    logic [QW-1:0] r_low, n_low;
    logic [QW-1:0] r_quot, n_quot;
    logic [24:0]   trial;
    logic [24:0]   diff;

    // The caller starts with a partial remainder below the divisor, so the
    // quotient fits in QW bits and the remainder stays below 2^24.
    always_comb begin
        trial  = {r_rem, r_low[QW-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_low  = r_low;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.rem_init;
            n_low  = i_req.low;
            n_dvs  = i_req.divisor;
            n_quot = '0;
        end else if (r_busy) begin
            if (!diff[24]) begin
                n_rem  = diff[23:0];
                n_quot = {r_quot[QW-2:0], 1'b1};
            end else begin
                n_rem  = trial[23:0];
                n_quot = {r_quot[QW-2:0], 1'b0};
            end
            n_low = {r_low[QW-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quot = r_quot;

endmodule

// ===== src/transient_restore_gain.sv =====
// Top level of the transient restore gain block: state memory, sequencer and shared multiplier.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  s         in         i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser
//  m         out        o_m_tvalid / i_m_tready   o_m_tdata
//  cfg       in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
//  An item is finished before the next one is accepted. When attack depth is
//  nonzero it waits on the shared divider for the 16-step divisions: the gain
//  division always, the transient division only when the transient needs one.
//  With attack depth zero, and for an unused channel, no division is made.
//  Reset is synchronous and clears the per-channel valid bits at once, so the
//  state memory reads as zero until a channel is first written.
//  A result waits in the output register; a stalled output holds the block only
//  when the next result is ready to leave.

module transient_restore_gain #(
    parameter int CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // sample_in[23:0], drive_target[39:24]
    input  logic        i_s_tuser,   // channel[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // transient_gain[15:0], smoothed_drive[31:16]
    input  logic        i_cfg_we,
    input  logic [trg_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    trg_pkg::t_state r_state, n_state;

    logic [15:0] r_fast_att, r_fast_rel, r_slow_att, r_slow_rel;
    logic [15:0] r_smooth, r_adepth, r_dscale;

    trg_pkg::t_env_entry r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    trg_pkg::t_env_entry r_rd;
    logic                r_rd_ok;

    logic [CW-1:0] r_ch;
    logic          r_skip;
    logic [23:0]   r_mag;
    logic [15:0]   r_target;
    logic [23:0]   r_fe, r_se;
    logic [15:0]   r_drive;
    logic          r_up;
    logic [42:0]   r_prod;
    logic          r_hsat;
    logic [16:0]   r_t;
    logic          r_t_div;
    logic [15:0]   r_depth;
    logic [16:0]   r_num;
    logic [15:0]   r_gain;
    logic          r_out_valid;
    logic [15:0]   r_out_gain, r_out_drive;

    logic          s_accept;
    logic          in_ok;
    logic [CW-1:0] rd_addr;
    logic [23:0]   raw;
    logic [23:0]   mag_in;
    logic [15:0]   target_in;

    trg_pkg::t_env_entry old_entry;
    trg_pkg::t_env_entry wr_entry;
    logic        drv_up;
    logic [15:0] drv_diff, drv_new;
    logic        fast_up, slow_up;
    logic [23:0] fast_diff, slow_diff;
    logic [23:0] env_step;
    logic [16:0] rnd_q16;
    logic [16:0] hard, factor, den, t_val;
    logic [15:0] depth;
    logic [23:0] t_diff, t_dv;
    logic        t_need_div, t_wait;
    logic [31:0] gdividend;
    logic        out_free;

    logic        mul_en;
    logic [23:0] mul_a;
    logic [18:0] mul_b;
    logic        out_load, mem_we;

    trg_pkg::t_div_req  div_req;
    trg_pkg::t_div_stat div_stat;

    trg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    // Input side.
    always_comb begin
        s_accept  = i_s_tvalid && o_s_tready;
        in_ok     = (CHANNELS > 1) || !i_s_tuser;
        rd_addr   = in_ok ? CW'(i_s_tuser) : '0;
        raw       = i_s_tdata[23:0];
        if (raw == trg_pkg::MAG_MIN) begin
            mag_in = trg_pkg::MAG_MAX;
        end else if (raw[23]) begin
            mag_in = ~raw + 24'd1;
        end else begin
            mag_in = raw;
        end
        target_in = (i_s_tdata[39:24] == 16'd0) ? 16'd1 : i_s_tdata[39:24];
    end

    // Datapath arithmetic around the shared multiplier.
    always_comb begin
        old_entry = r_rd_ok ? r_rd : '0;
        drv_up    = old_entry.drive >= r_target;
        drv_diff  = drv_up ? (old_entry.drive - r_target) : (r_target - old_entry.drive);
        // The drive moves toward the target by the truncated product.
        drv_new   = r_up ? (r_target + r_prod[31:16]) : (r_target - r_prod[31:16]);

        fast_up   = r_mag > r_fe;
        fast_diff = fast_up ? (r_mag - r_fe) : (r_fe - r_mag);
        slow_up   = r_mag > r_se;
        slow_diff = slow_up ? (r_mag - r_se) : (r_se - r_mag);
        env_step  = r_prod[39:16] + {23'd0, r_prod[15]};

        rnd_q16   = r_prod[32:16] + {16'd0, r_prod[15]};
        hard      = r_hsat ? trg_pkg::ONE_Q16 : {1'b0, r_prod[35:20]};
        factor    = {1'b0, trg_pkg::K035} + rnd_q16;
        depth     = rnd_q16[15:0];
        den       = trg_pkg::ONE_Q16 + rnd_q16;
        gdividend = {1'b0, r_num, 14'd0} + {16'd0, den[16:1]};

        t_diff     = r_fe - r_se;
        t_dv       = r_se + trg_pkg::EPS_Q23;
        t_need_div = (r_fe > r_se) && (t_diff < t_dv);
        t_wait     = r_t_div && div_stat.busy;
        t_val      = r_t_div ? {1'b0, div_stat.quot} : r_t;

        out_free = !r_out_valid || i_m_tready;

        wr_entry.fast  = r_fe;
        wr_entry.slow  = r_se;
        wr_entry.drive = r_drive;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = in_ok ? trg_pkg::ST_DRIVE : trg_pkg::ST_DONE;
                end
            end
            trg_pkg::ST_DRIVE:  n_state = trg_pkg::ST_FAST;
            trg_pkg::ST_FAST: begin
                n_state = (r_adepth == 16'd0) ? trg_pkg::ST_DONE : trg_pkg::ST_SLOW;
            end
            trg_pkg::ST_SLOW:   n_state = trg_pkg::ST_HARD;
            trg_pkg::ST_HARD:   n_state = trg_pkg::ST_DIV3;
            trg_pkg::ST_DIV3:   n_state = trg_pkg::ST_FACTOR;
            trg_pkg::ST_FACTOR: n_state = trg_pkg::ST_DEPTH;
            trg_pkg::ST_DEPTH:  n_state = trg_pkg::ST_NUM;
            trg_pkg::ST_NUM: begin
                if (!t_wait) begin
                    n_state = trg_pkg::ST_DEN;
                end
            end
            trg_pkg::ST_DEN:    n_state = trg_pkg::ST_GDIV;
            trg_pkg::ST_GDIV:   n_state = trg_pkg::ST_GWAIT;
            trg_pkg::ST_GWAIT: begin
                if (!div_stat.busy) begin
                    n_state = trg_pkg::ST_DONE;
                end
            end
            trg_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = trg_pkg::ST_IDLE;
                end
            end
            default: n_state = trg_pkg::ST_IDLE;
        endcase
    end

    // Per-state controls: multiplier operands, divider requests, write-back.
    always_comb begin
        o_s_tready = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        unique case (r_state)
            trg_pkg::ST_IDLE: o_s_tready = 1'b1;
            trg_pkg::ST_DRIVE: begin
                mul_en = 1'b1;
                mul_a  = 24'(drv_diff);
                mul_b  = 19'(r_smooth);
            end
            trg_pkg::ST_FAST: begin
                mul_en = 1'b1;
                mul_a  = fast_diff;
                mul_b  = 19'(fast_up ? r_fast_att : r_fast_rel);
            end
            trg_pkg::ST_SLOW: begin
                mul_en = 1'b1;
                mul_a  = slow_diff;
                mul_b  = 19'(slow_up ? r_slow_att : r_slow_rel);
            end
            trg_pkg::ST_HARD: begin
                mul_en = 1'b1;
                mul_a  = 24'(r_drive);
                mul_b  = 19'(r_dscale);
            end
            trg_pkg::ST_DIV3: begin
                // Divide drive * scale / 4096 by three through the reciprocal.
                mul_en = 1'b1;
                mul_a  = 24'(r_prod[31:12]);
                mul_b  = trg_pkg::RECIP3;
                div_req.start    = t_need_div;
                div_req.rem_init = t_diff;
                div_req.low      = '0;
                div_req.divisor  = t_dv;
            end
            trg_pkg::ST_FACTOR: begin
                mul_en = 1'b1;
                mul_a  = 24'(trg_pkg::K065);
                mul_b  = 19'(hard);
            end
            trg_pkg::ST_DEPTH: begin
                mul_en = 1'b1;
                mul_a  = 24'(r_adepth);
                mul_b  = 19'(factor);
            end
            trg_pkg::ST_NUM: begin
                mul_en = !t_wait;
                mul_a  = 24'(depth);
                mul_b  = 19'(t_val);
            end
            trg_pkg::ST_DEN: begin
                mul_en = 1'b1;
                mul_a  = 24'(r_depth);
                mul_b  = 19'(trg_pkg::K028);
            end
            trg_pkg::ST_GDIV: begin
                // The quotient stays below 2^16, so the upper half of the
                // dividend is already below the divisor.
                div_req.start    = 1'b1;
                div_req.rem_init = 24'(gdividend[31:16]);
                div_req.low      = gdividend[15:0];
                div_req.divisor  = 24'(den);
            end
            trg_pkg::ST_GWAIT: ;
            trg_pkg::ST_DONE: begin
                out_load = out_free;
                mem_we   = out_free && !r_skip;
            end
            default: ;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trg_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_fast_att  <= 16'd2675;
            r_fast_rel  <= 16'd45;
            r_slow_att  <= 16'd91;
            r_slow_rel  <= 16'd9;
            r_smooth    <= 16'd65263;
            r_adepth    <= 16'd19661;
            r_dscale    <= 16'd16384;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_valid[r_ch] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    trg_pkg::CFG_FAST_ATTACK:  r_fast_att <= i_cfg_wdata;
                    trg_pkg::CFG_FAST_RELEASE: r_fast_rel <= i_cfg_wdata;
                    trg_pkg::CFG_SLOW_ATTACK:  r_slow_att <= i_cfg_wdata;
                    trg_pkg::CFG_SLOW_RELEASE: r_slow_rel <= i_cfg_wdata;
                    trg_pkg::CFG_SMOOTHING:    r_smooth   <= i_cfg_wdata;
                    trg_pkg::CFG_ATTACK_DEPTH: r_adepth   <= i_cfg_wdata;
                    trg_pkg::CFG_DRIVE_SCALE:  r_dscale   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // State memory: read on accept, written back when the result is loaded into the output register.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd    <= r_mem[rd_addr];
            r_rd_ok <= r_valid[rd_addr];
        end
        if (mem_we) begin
            r_mem[r_ch] <= wr_entry;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= 43'(mul_a) * 43'(mul_b);
        end
        if (s_accept) begin
            r_ch     <= rd_addr;
            r_skip   <= !in_ok;
            r_mag    <= mag_in;
            r_target <= target_in;
            r_gain   <= trg_pkg::UNITY_Q14;
        end
        if (out_load) begin
            r_out_gain  <= r_gain;
            r_out_drive <= r_skip ? 16'd0 : r_drive;
        end
        case (r_state)
            trg_pkg::ST_DRIVE: begin
                r_fe <= old_entry.fast;
                r_se <= old_entry.slow;
                r_up <= drv_up;
            end
            trg_pkg::ST_FAST: begin
                r_drive <= drv_new;
                r_up    <= fast_up;
            end
            trg_pkg::ST_SLOW: begin
                r_fe <= r_up ? (r_fe + env_step) : (r_fe - env_step);
                r_up <= slow_up;
            end
            trg_pkg::ST_HARD: begin
                r_se <= r_up ? (r_se + env_step) : (r_se - env_step);
            end
            trg_pkg::ST_DIV3: begin
                r_hsat  <= r_prod[31:0] >= trg_pkg::HARD_SAT;
                r_t_div <= t_need_div;
                r_t     <= (r_fe > r_se) ? trg_pkg::ONE_Q16 : 17'd0;
            end
            trg_pkg::ST_NUM: begin
                r_depth <= depth;
            end
            trg_pkg::ST_DEN: begin
                r_num <= trg_pkg::ONE_Q16 + rnd_q16;
            end
            trg_pkg::ST_GWAIT: begin
                if (!div_stat.busy) begin
                    r_gain <= div_stat.quot;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_drive, r_out_gain};

endmodule

// ===== src/trg_chk.sv =====
// Port-level checks of the transient restore gain block and their bind.
`timescale 1ns / 1ps

module trg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_addr,
    input logic [15:0] i_cfg_wdata
);

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output item changed while stalled");

    // One item at a time: the input closes right after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is at work");

    // A result is loaded only from the finishing step, never while idle.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without an item being finished");

    // The level-neutral gain stays below 2.0.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[15])
        else $error("transient gain out of range");

endmodule

bind transient_restore_gain trg_chk u_trg_chk (.*);
